// ===== rtl/core/gpshsc_pkg.sv =====
package gpshsc_pkg;

  // multiplier operand widths
  localparam int MulAW = 64;
  localparam int MulBW = 33;

  // fixed-point constants
  localparam logic signed [32:0] LAT_SCALE   = 33'sd7860264;
  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ERR_ROUND   = 34'sd65536;
  localparam logic signed [33:0] ERR_MAX     = 34'sd25736;
  localparam logic signed [38:0] INTEG_MAX   = 39'sd6710886;
  localparam logic [25:0]        TICK_DIV    = 26'd31250000;
  localparam logic signed [32:0] LIM_COEF    = 33'sd222948;
  localparam logic signed [33:0] LIM_SPAN    = 34'sd524288;
  localparam logic [35:0]        SPD_INTEG   = 36'd360000;
  localparam logic [35:0]        SPD_PROP    = 36'd250000;
  localparam logic [52:0]        NORM_HI     = 53'd1073741824;
  localparam logic [52:0]        NORM_LO     = 53'd536870912;
  localparam logic signed [35:0] RATE_MAX    = 36'sd2147483647;
  localparam logic signed [35:0] RATE_MIN    = -36'sd2147483648;
  localparam int                 DIV_STEPS   = 37;

  // configuration register indexes
  localparam logic [1:0] REG_CRUISE   = 2'd0;
  localparam logic [1:0] REG_HGAIN    = 2'd1;
  localparam logic [1:0] REG_IGAIN    = 2'd2;
  localparam logic [1:0] REG_REVERSE  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_WAIT,
    ST_COS,
    ST_NPREP,
    ST_NORM_R,
    ST_NORM_L,
    ST_VPREP,
    ST_VEC,
    ST_ERR,
    ST_INTEG,
    ST_DIV,
    ST_INT_UPD,
    ST_PROP,
    ST_RATE,
    ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_THETA,
    OP_DLON,
    OP_VN2,
    OP_VE2,
    OP_Y1,
    OP_Y2,
    OP_X1,
    OP_X2,
    OP_EG,
    OP_EGT,
    OP_PROP,
    OP_DLAT2,
    OP_DLON2,
    OP_LIM
  } op_e;

  typedef struct packed {
    logic                    start;
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [MulAW-1:0] p;
  } mul_rsp_t;

  // arctangent of 2^-i in Q30
  function automatic logic [29:0] atan_val(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/gpshsc_if.sv =====
interface gpshsc_in_if;
  logic                valid;
  logic                ready;
  logic                fix_valid;
  logic signed [30:0]  fix_lat;
  logic signed [31:0]  fix_lon;
  logic signed [30:0]  target_lat;
  logic signed [31:0]  target_lon;
  logic signed [17:0]  vel_north;
  logic signed [17:0]  vel_east;
  logic [29:0]         tick_ns;

  modport source (
    output valid, fix_valid, fix_lat, fix_lon, target_lat, target_lon,
           vel_north, vel_east, tick_ns,
    input  ready
  );
  modport sink (
    input  valid, fix_valid, fix_lat, fix_lon, target_lat, target_lon,
           vel_north, vel_east, tick_ns,
    output ready
  );
endinterface

interface gpshsc_out_if;
  logic                valid;
  logic                ready;
  logic [15:0]         linear_speed;
  logic signed [31:0]  angular_rate;
  logic signed [15:0]  heading_error;

  modport source (
    output valid, linear_speed, angular_rate, heading_error,
    input  ready
  );
  modport sink (
    input  valid, linear_speed, angular_rate, heading_error,
    output ready
  );
endinterface

// ===== rtl/core/gps_heading_steering_controller_top.sv =====
// GPS heading steering controller. Each input transfer carries one control
// tick; a tick without a fix is taken and dropped, a tick with a fix yields
// exactly one result transfer (cruise speed, steering rate, heading error).
// One tick is worked on at a time; a finished result waits in the output
// register, so the next tick is taken while it is still pending. A tick passes
// through about fourteen products on the shared digit-serial multiplier (4
// multiplier bits per cycle, stopping early for small operands), two CORDIC
// passes of CORDIC_STEPS iterations each (target-latitude cosine, then the
// heading angle), a one-bit-per-cycle normalizing shift of the cross/dot
// vector, and a restoring divide of DIV_STEPS quotient bits for the integral
// step when the ground speed is above 600 mm/s.
// Configuration writes go to cfg_idx_i at any edge with cfg_we_i high and
// must only happen while the block is idle. The integral state resets to 0.
module gps_heading_steering_controller_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  gpshsc_in_if.sink   in_i,
  gpshsc_out_if.source out_o
);

  localparam logic [5:0] LastStep = 6'(CORDIC_STEPS - 1);
  localparam logic [5:0] LastDiv  = 6'(gpshsc_pkg::DIV_STEPS - 1);

  gpshsc_pkg::state_e state_q, state_d;
  gpshsc_pkg::op_e    op_q, op_d;

  gpshsc_pkg::mul_req_t mul_req;
  gpshsc_pkg::mul_rsp_t mul_rsp;

  // configuration
  logic [15:0] cruise_q, hgain_q, igain_q;
  logic        rev_q;

  // captured tick
  logic signed [31:0] dlat_q;
  logic signed [32:0] dlonr_q;
  logic signed [30:0] tlat_q;
  logic signed [17:0] vn_q, ve_q;
  logic [29:0]        tick_q;

  // working registers
  logic signed [33:0] x_q, y_q, ang_q;
  logic               cneg_q;
  logic [5:0]         cnt_q;
  logic signed [33:0] dlon_q;
  logic [35:0]        spd_q;
  logic signed [53:0] yv_q, xv_q;
  logic [52:0]        m_q;
  logic signed [15:0] err_q;
  logic signed [63:0] prod_q;
  logic [24:0]        rem_q;
  logic [36:0]        dvd_q;
  logic signed [23:0] integ_q;
  logic signed [37:0] acc_q;
  logic signed [35:0] rate_q;

  // output register
  logic               ov_q;
  logic [15:0]        o_lin_q;
  logic signed [31:0] o_rate_q;
  logic signed [15:0] o_err_q;

  logic in_fire, out_free, small_d;

  // combinational helpers
  logic signed [33:0] theta, t_abs, t_cl, t_fold;
  logic signed [33:0] c_mag;
  logic signed [32:0] c_val;
  logic [4:0]         sh;
  logic signed [33:0] xs, ys, atn;
  logic signed [33:0] e_full, e_cl;
  logic [25:0]        r2;
  logic               r_ge;
  logic [35:0]        spd_new;
  logic signed [53:0] xv_new;
  logic [52:0]        ax, ay;
  logic signed [38:0] q_s, isum, icl;
  logic signed [37:0] rsum;
  logic signed [35:0] lim, rneg, rsat;
  logic [15:0]        err_abs;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign small_d  = (34'(dlat_q) < LIM_SPAN_P) && (34'(dlat_q) > -LIM_SPAN_P) &&
                    (dlon_q < LIM_SPAN_P) && (dlon_q > -LIM_SPAN_P);

  localparam logic signed [33:0] LIM_SPAN_P = gpshsc_pkg::LIM_SPAN;

  always_comb begin
    theta  = $signed(mul_rsp.p[55:22]);
    t_abs  = theta[33] ? -theta : theta;
    t_cl   = (t_abs > gpshsc_pkg::Q30_PI) ? gpshsc_pkg::Q30_PI : t_abs;
    t_fold = (t_cl > gpshsc_pkg::Q30_HALF_PI) ? (gpshsc_pkg::Q30_PI - t_cl) : t_cl;

    c_mag = x_q[33] ? '0 : ((x_q > gpshsc_pkg::Q30_ONE) ? gpshsc_pkg::Q30_ONE : x_q);
    c_val = cneg_q ? 33'(-c_mag) : 33'(c_mag);

    sh  = cnt_q[4:0];
    xs  = x_q >>> sh;
    ys  = y_q >>> sh;
    atn = $signed({4'b0000, gpshsc_pkg::atan_val(sh)});

    e_full = (ang_q + gpshsc_pkg::ERR_ROUND) >>> 17;
    if (e_full > gpshsc_pkg::ERR_MAX) begin
      e_cl = gpshsc_pkg::ERR_MAX;
    end else if (e_full < -gpshsc_pkg::ERR_MAX) begin
      e_cl = -gpshsc_pkg::ERR_MAX;
    end else begin
      e_cl = e_full;
    end

    r2   = {rem_q, dvd_q[36]};
    r_ge = (r2 >= gpshsc_pkg::TICK_DIV);

    spd_new = spd_q + mul_rsp.p[35:0];
    xv_new  = xv_q + mul_rsp.p[53:0];
    ax      = xv_q[53] ? 53'(-xv_q) : 53'(xv_q);
    ay      = yv_q[53] ? 53'(-yv_q) : 53'(yv_q);

    q_s  = err_q[15] ? -$signed({2'b00, dvd_q}) : $signed({2'b00, dvd_q});
    isum = 39'(integ_q) + q_s;
    if (isum > gpshsc_pkg::INTEG_MAX) begin
      icl = gpshsc_pkg::INTEG_MAX;
    end else if (isum < -gpshsc_pkg::INTEG_MAX) begin
      icl = -gpshsc_pkg::INTEG_MAX;
    end else begin
      icl = isum;
    end

    rsum = (acc_q + 38'(integ_q)) >>> 10;
    lim  = $signed({2'b00, mul_rsp.p[57:24]});
    rneg = rev_q ? -rate_q : rate_q;
    if (rneg > gpshsc_pkg::RATE_MAX) begin
      rsat = gpshsc_pkg::RATE_MAX;
    end else if (rneg < gpshsc_pkg::RATE_MIN) begin
      rsat = gpshsc_pkg::RATE_MIN;
    end else begin
      rsat = rneg;
    end

    err_abs = err_q[15] ? 16'(-err_q) : 16'(err_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      gpshsc_pkg::ST_IDLE: begin
        if (in_fire && in_i.fix_valid) begin
          state_d = gpshsc_pkg::ST_MUL;
          op_d    = gpshsc_pkg::OP_THETA;
        end
      end
      gpshsc_pkg::ST_MUL: state_d = gpshsc_pkg::ST_WAIT;
      gpshsc_pkg::ST_WAIT: begin
        if (mul_rsp.done) begin
          state_d = gpshsc_pkg::ST_MUL;
          case (op_q)
            gpshsc_pkg::OP_THETA: state_d = gpshsc_pkg::ST_COS;
            gpshsc_pkg::OP_DLON:  op_d = gpshsc_pkg::OP_VN2;
            gpshsc_pkg::OP_VN2:   op_d = gpshsc_pkg::OP_VE2;
            gpshsc_pkg::OP_VE2: begin
              if ((spd_new != '0) && ((dlat_q != '0) || (dlon_q != '0))) begin
                op_d = gpshsc_pkg::OP_Y1;
              end else begin
                state_d = gpshsc_pkg::ST_INTEG;
              end
            end
            gpshsc_pkg::OP_Y1:    op_d = gpshsc_pkg::OP_Y2;
            gpshsc_pkg::OP_Y2:    op_d = gpshsc_pkg::OP_X1;
            gpshsc_pkg::OP_X1:    op_d = gpshsc_pkg::OP_X2;
            gpshsc_pkg::OP_X2:    state_d = gpshsc_pkg::ST_NPREP;
            gpshsc_pkg::OP_EG:    op_d = gpshsc_pkg::OP_EGT;
            gpshsc_pkg::OP_EGT:   state_d = gpshsc_pkg::ST_DIV;
            gpshsc_pkg::OP_PROP:  state_d = gpshsc_pkg::ST_RATE;
            gpshsc_pkg::OP_DLAT2: op_d = gpshsc_pkg::OP_DLON2;
            gpshsc_pkg::OP_DLON2: op_d = gpshsc_pkg::OP_LIM;
            gpshsc_pkg::OP_LIM:   state_d = gpshsc_pkg::ST_FIN;
            default:              state_d = gpshsc_pkg::ST_IDLE;
          endcase
        end
      end
      gpshsc_pkg::ST_COS: begin
        if (cnt_q == LastStep) begin
          state_d = gpshsc_pkg::ST_MUL;
          op_d    = gpshsc_pkg::OP_DLON;
        end
      end
      gpshsc_pkg::ST_NPREP: begin
        if ((xv_q == '0) && (yv_q == '0)) begin
          state_d = gpshsc_pkg::ST_INTEG;
        end else begin
          state_d = gpshsc_pkg::ST_NORM_R;
        end
      end
      gpshsc_pkg::ST_NORM_R: begin
        if (m_q < gpshsc_pkg::NORM_HI) state_d = gpshsc_pkg::ST_NORM_L;
      end
      gpshsc_pkg::ST_NORM_L: begin
        if ((m_q == '0) || (m_q >= gpshsc_pkg::NORM_LO)) state_d = gpshsc_pkg::ST_VPREP;
      end
      gpshsc_pkg::ST_VPREP: state_d = gpshsc_pkg::ST_VEC;
      gpshsc_pkg::ST_VEC: begin
        if (cnt_q == LastStep) state_d = gpshsc_pkg::ST_ERR;
      end
      gpshsc_pkg::ST_ERR: state_d = gpshsc_pkg::ST_INTEG;
      gpshsc_pkg::ST_INTEG: begin
        if (spd_q > gpshsc_pkg::SPD_INTEG) begin
          state_d = gpshsc_pkg::ST_MUL;
          op_d    = gpshsc_pkg::OP_EG;
        end else begin
          state_d = gpshsc_pkg::ST_INT_UPD;
        end
      end
      gpshsc_pkg::ST_DIV: begin
        if (cnt_q == LastDiv) state_d = gpshsc_pkg::ST_INT_UPD;
      end
      gpshsc_pkg::ST_INT_UPD: state_d = gpshsc_pkg::ST_PROP;
      gpshsc_pkg::ST_PROP: begin
        if (spd_q > gpshsc_pkg::SPD_PROP) begin
          state_d = gpshsc_pkg::ST_MUL;
          op_d    = gpshsc_pkg::OP_PROP;
        end else begin
          state_d = gpshsc_pkg::ST_RATE;
        end
      end
      gpshsc_pkg::ST_RATE: begin
        if (small_d) begin
          state_d = gpshsc_pkg::ST_MUL;
          op_d    = gpshsc_pkg::OP_DLAT2;
        end else begin
          state_d = gpshsc_pkg::ST_FIN;
        end
      end
      gpshsc_pkg::ST_FIN: begin
        if (out_free) state_d = gpshsc_pkg::ST_IDLE;
      end
      default: state_d = gpshsc_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake and multiplier operands
  always_comb begin
    in_i.ready    = (state_q == gpshsc_pkg::ST_IDLE);
    mul_req.start = (state_q == gpshsc_pkg::ST_MUL);
    mul_req.a     = '0;
    mul_req.b     = '0;
    case (op_q)
      gpshsc_pkg::OP_THETA: begin
        mul_req.a = 64'(tlat_q);
        mul_req.b = gpshsc_pkg::LAT_SCALE;
      end
      gpshsc_pkg::OP_DLON: begin
        mul_req.a = 64'(dlonr_q);
        mul_req.b = c_val;
      end
      gpshsc_pkg::OP_VN2: begin
        mul_req.a = 64'(vn_q);
        mul_req.b = 33'(vn_q);
      end
      gpshsc_pkg::OP_VE2: begin
        mul_req.a = 64'(ve_q);
        mul_req.b = 33'(ve_q);
      end
      gpshsc_pkg::OP_Y1: begin
        mul_req.a = 64'(dlat_q);
        mul_req.b = 33'(ve_q);
      end
      gpshsc_pkg::OP_Y2: begin
        mul_req.a = 64'(dlon_q);
        mul_req.b = 33'(vn_q);
      end
      gpshsc_pkg::OP_X1: begin
        mul_req.a = 64'(dlat_q);
        mul_req.b = 33'(vn_q);
      end
      gpshsc_pkg::OP_X2: begin
        mul_req.a = 64'(dlon_q);
        mul_req.b = 33'(ve_q);
      end
      gpshsc_pkg::OP_EG: begin
        mul_req.a = $signed({48'b0, err_abs});
        mul_req.b = $signed({17'b0, igain_q});
      end
      gpshsc_pkg::OP_EGT: begin
        mul_req.a = prod_q;
        mul_req.b = $signed({3'b000, tick_q});
      end
      gpshsc_pkg::OP_PROP: begin
        mul_req.a = 64'(err_q);
        mul_req.b = $signed({17'b0, hgain_q});
      end
      gpshsc_pkg::OP_DLAT2: begin
        mul_req.a = 64'(dlat_q);
        mul_req.b = 33'(dlat_q);
      end
      gpshsc_pkg::OP_DLON2: begin
        mul_req.a = 64'(dlon_q);
        mul_req.b = dlon_q[32:0];
      end
      gpshsc_pkg::OP_LIM: begin
        mul_req.a = prod_q;
        mul_req.b = gpshsc_pkg::LIM_COEF;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  gpshsc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // control state, configuration, integral and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gpshsc_pkg::ST_IDLE;
      op_q     <= gpshsc_pkg::OP_THETA;
      cruise_q <= 16'd1500;
      hgain_q  <= 16'd128;
      igain_q  <= 16'd0;
      rev_q    <= 1'b0;
      integ_q  <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gpshsc_pkg::REG_CRUISE:  cruise_q <= cfg_data_i;
          gpshsc_pkg::REG_HGAIN:   hgain_q  <= cfg_data_i;
          gpshsc_pkg::REG_IGAIN:   igain_q  <= cfg_data_i;
          gpshsc_pkg::REG_REVERSE: rev_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      // clamp the integral on every tick with a fix
      if (state_q == gpshsc_pkg::ST_INT_UPD) integ_q <= icl[23:0];
      if ((state_q == gpshsc_pkg::ST_FIN) && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      gpshsc_pkg::ST_IDLE: begin
        if (in_fire) begin
          dlat_q  <= 32'(in_i.target_lat) - 32'(in_i.fix_lat);
          dlonr_q <= 33'(in_i.target_lon) - 33'(in_i.fix_lon);
          tlat_q  <= in_i.target_lat;
          vn_q    <= in_i.vel_north;
          ve_q    <= in_i.vel_east;
          tick_q  <= in_i.tick_ns;
          err_q   <= '0;
        end
      end
      gpshsc_pkg::ST_WAIT: begin
        if (mul_rsp.done) begin
          case (op_q)
            gpshsc_pkg::OP_THETA: begin
              // fold the latitude angle into the first quadrant
              x_q    <= gpshsc_pkg::CORDIC_GAIN;
              y_q    <= '0;
              ang_q  <= t_fold;
              cneg_q <= (t_cl > gpshsc_pkg::Q30_HALF_PI);
              cnt_q  <= '0;
            end
            gpshsc_pkg::OP_DLON:  dlon_q <= mul_rsp.p[63:30];
            gpshsc_pkg::OP_VN2:   spd_q  <= mul_rsp.p[35:0];
            gpshsc_pkg::OP_VE2:   spd_q  <= spd_new;
            gpshsc_pkg::OP_Y1:    yv_q   <= mul_rsp.p[53:0];
            gpshsc_pkg::OP_Y2:    yv_q   <= yv_q - mul_rsp.p[53:0];
            gpshsc_pkg::OP_X1:    xv_q   <= mul_rsp.p[53:0];
            gpshsc_pkg::OP_X2:    xv_q   <= xv_new;
            gpshsc_pkg::OP_EG:    prod_q <= mul_rsp.p;
            gpshsc_pkg::OP_EGT: begin
              // top bits are below the divisor, so start the divide there
              rem_q <= {1'b0, mul_rsp.p[60:37]};
              dvd_q <= mul_rsp.p[36:0];
              cnt_q <= '0;
            end
            gpshsc_pkg::OP_PROP:  acc_q  <= $signed({mul_rsp.p[32:0], 5'b00000});
            gpshsc_pkg::OP_DLAT2: prod_q <= mul_rsp.p;
            gpshsc_pkg::OP_DLON2: prod_q <= prod_q + mul_rsp.p;
            gpshsc_pkg::OP_LIM: begin
              if (rate_q > lim) begin
                rate_q <= lim;
              end else if (rate_q < -lim) begin
                rate_q <= -lim;
              end
            end
            default: ;
          endcase
        end
      end
      gpshsc_pkg::ST_COS: begin
        // rotate toward the residual angle
        if (!ang_q[33]) begin
          x_q   <= x_q - ys;
          y_q   <= y_q + xs;
          ang_q <= ang_q - atn;
        end else begin
          x_q   <= x_q + ys;
          y_q   <= y_q - xs;
          ang_q <= ang_q + atn;
        end
        cnt_q <= cnt_q + 6'd1;
      end
      gpshsc_pkg::ST_NPREP: m_q <= (ax > ay) ? ax : ay;
      gpshsc_pkg::ST_NORM_R: begin
        if (m_q >= gpshsc_pkg::NORM_HI) begin
          xv_q <= xv_q >>> 1;
          yv_q <= yv_q >>> 1;
          m_q  <= m_q >> 1;
        end
      end
      gpshsc_pkg::ST_NORM_L: begin
        if ((m_q != '0) && (m_q < gpshsc_pkg::NORM_LO)) begin
          xv_q <= xv_q <<< 1;
          yv_q <= yv_q <<< 1;
          m_q  <= m_q << 1;
        end
      end
      gpshsc_pkg::ST_VPREP: begin
        // move a left-half vector to the right half, starting from +-pi
        if (xv_q[53]) begin
          x_q   <= -xv_q[33:0];
          y_q   <= -yv_q[33:0];
          ang_q <= yv_q[53] ? -gpshsc_pkg::Q30_PI : gpshsc_pkg::Q30_PI;
        end else begin
          x_q   <= xv_q[33:0];
          y_q   <= yv_q[33:0];
          ang_q <= '0;
        end
        cnt_q <= '0;
      end
      gpshsc_pkg::ST_VEC: begin
        // drive y toward zero and sum the angle
        if (!y_q[33] && (y_q != '0)) begin
          x_q   <= x_q + ys;
          y_q   <= y_q - xs;
          ang_q <= ang_q + atn;
        end else begin
          x_q   <= x_q - ys;
          y_q   <= y_q + xs;
          ang_q <= ang_q - atn;
        end
        cnt_q <= cnt_q + 6'd1;
      end
      gpshsc_pkg::ST_ERR:   err_q <= e_cl[15:0];
      gpshsc_pkg::ST_INTEG: dvd_q <= '0;
      gpshsc_pkg::ST_DIV: begin
        rem_q <= r_ge ? 25'(r2 - gpshsc_pkg::TICK_DIV) : r2[24:0];
        dvd_q <= {dvd_q[35:0], r_ge};
        cnt_q <= cnt_q + 6'd1;
      end
      gpshsc_pkg::ST_PROP:  acc_q  <= '0;
      gpshsc_pkg::ST_RATE:  rate_q <= rsum[35:0];
      gpshsc_pkg::ST_FIN: begin
        if (out_free) begin
          o_lin_q  <= cruise_q;
          o_rate_q <= rsat[31:0];
          o_err_q  <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid         = ov_q;
  assign out_o.linear_speed  = o_lin_q;
  assign out_o.angular_rate  = o_rate_q;
  assign out_o.heading_error = o_err_q;

endmodule

// ===== rtl/core/gpshsc_mul.sv =====
// Digit-serial signed multiplier: one 4-bit digit of |b| per cycle, stop when
// the remaining digits are zero.
module gpshsc_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gpshsc_pkg::mul_req_t req_i,
  output gpshsc_pkg::mul_rsp_t rsp_o
);

  logic                                busy_q;
  logic                                done_q;
  logic signed [gpshsc_pkg::MulAW-1:0] a_q;
  logic [gpshsc_pkg::MulBW-1:0]        b_q;
  logic                                neg_q;
  logic signed [gpshsc_pkg::MulAW-1:0] acc_q;
  logic signed [gpshsc_pkg::MulAW-1:0] p_q;
  logic signed [gpshsc_pkg::MulAW-1:0] part;
  logic [gpshsc_pkg::MulBW-1:0]        b_abs;

  assign part  = a_q * $signed({1'b0, b_q[3:0]});
  assign b_abs = req_i.b[gpshsc_pkg::MulBW-1] ? gpshsc_pkg::MulBW'(-req_i.b)
                                                : gpshsc_pkg::MulBW'(req_i.b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (b_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= b_abs;
      neg_q <= req_i.b[gpshsc_pkg::MulBW-1];
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q != '0) begin
        acc_q <= acc_q + part;
        a_q   <= a_q <<< 4;
        b_q   <= b_q >> 4;
      end else begin
        p_q <= neg_q ? -acc_q : acc_q;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = p_q;

endmodule

// ===== tb/gps_heading_steering_controller_top_tb.sv =====
module gps_heading_steering_controller_top_tb;
  import gpshsc_pkg::*;

  localparam int      STEPS      = 16;
  localparam int      DRAIN      = 400;      // worst tick plus margin
  localparam longint  CYCLE_CAP  = 1500000;
  localparam longint  PI_Q30     = 64'sd3373259426;
  localparam longint  HALF_PI    = 64'sd1686629713;
  localparam longint  ONE_Q30    = 64'sd1073741824;
  localparam longint  GAIN_INV   = 64'sd652032874;
  localparam longint  LAT_TO_RAD = 64'sd7860264;
  localparam longint  ERR_LIM    = 64'sd25736;
  localparam longint  INTEG_LIM  = 64'sd6710886;
  localparam longint  TICK_SCALE = 64'sd31250000;
  localparam longint  SPAN       = 64'sd524288;
  localparam longint  DIST_COEF  = 64'sd222948;

  localparam longint ATAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128
  };

  typedef struct {
    logic               fix;
    logic signed [30:0] flat;
    logic signed [31:0] flon;
    logic signed [30:0] tlat;
    logic signed [31:0] tlon;
    logic signed [17:0] vn;
    logic signed [17:0] ve;
    logic [29:0]        tick;
    bit                 typed;   // expected command given in the row
    logic [15:0]        t_speed;
    logic signed [31:0] t_rate;
    logic signed [15:0] t_err;
  } tick_t;

  typedef struct {
    logic [15:0]        speed;
    logic signed [31:0] rate;
    logic signed [15:0] err;
  } steer_cmd_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  gpshsc_in_if  tick_bus ();
  gpshsc_out_if cmd_bus ();

  gps_heading_steering_controller_top #(.CORDIC_STEPS(STEPS)) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (tick_bus),
    .out_o     (cmd_bus)
  );

  // shadow copy of the block's registers and integral
  longint cruise, hgain, igain, reverse, integ;

  steer_cmd_t cmd_q[$];
  int     fails;
  int     src_idle, snk_idle;
  longint cycles;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // hold the run to a bounded number of cycles
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL gps_heading_steering_controller_top");
      $finish;
    end
  end

  // stall the result side at random
  always @(posedge clk_i) begin
    if (!rst_ni) cmd_bus.ready <= 1'b0;
    else cmd_bus.ready <= ($urandom_range(99) >= snk_idle);
  end

  function automatic longint lat_cosine(longint theta);
    longint t, x, y, nx;
    bit neg;
    t = theta < 0 ? -theta : theta;
    neg = 0;
    x = GAIN_INV;
    y = 0;
    if (t > PI_Q30) t = PI_Q30;
    if (t > HALF_PI) begin
      t = PI_Q30 - t;
      neg = 1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (t >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); t -= ATAN_Q30[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); t += ATAN_Q30[i];
      end
      x = nx;
    end
    if (x < 0) x = 0;
    if (x > ONE_Q30) x = ONE_Q30;
    return neg ? -x : x;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint ax, ay, m, z, nx;
    int sh;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    m = ax > ay ? ax : ay;
    z = 0;
    sh = 0;
    while (m >= ONE_Q30) begin
      m = m >> 1; sh++;
    end
    if (sh != 0) begin
      x = x >>> sh; y = y >>> sh;
    end
    sh = 0;
    while (m != 0 && m < (ONE_Q30 >> 1)) begin
      m = m << 1; sh++;
    end
    x = x * (longint'(1) << sh);
    y = y * (longint'(1) << sh);
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30 : -PI_Q30;
      x = -x; y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_Q30[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_Q30[i];
      end
      x = nx;
    end
    return z;
  endfunction

  // compute the steering command of one tick with a fix; advance the integral
  function automatic steer_cmd_t steer_predict(tick_t t);
    steer_cmd_t c;
    longint dlat, dlon, cs, vn, ve, spd2, err, acc, rate, yv, xv, d2, lim;
    vn = longint'(t.vn);
    ve = longint'(t.ve);
    err = 0;
    dlat = longint'(t.tlat) - longint'(t.flat);
    cs = lat_cosine((longint'(t.tlat) * LAT_TO_RAD) >>> 22);
    dlon = ((longint'(t.tlon) - longint'(t.flon)) * cs) >>> 30;
    spd2 = vn * vn + ve * ve;
    if (spd2 != 0 && (dlat != 0 || dlon != 0)) begin
      yv = ve * dlat - vn * dlon;
      xv = vn * dlat + ve * dlon;
      if (yv != 0 || xv != 0) begin
        err = (vector_angle(yv, xv) + 65536) >>> 17;
        if (err > ERR_LIM) err = ERR_LIM;
        if (err < -ERR_LIM) err = -ERR_LIM;
      end
    end
    if (spd2 > 360000) integ += (err * igain * longint'(t.tick)) / TICK_SCALE;
    if (integ > INTEG_LIM) integ = INTEG_LIM;
    if (integ < -INTEG_LIM) integ = -INTEG_LIM;
    acc = (spd2 > 250000) ? err * hgain * 32 : 0;
    rate = (acc + integ) >>> 10;
    if (dlat < SPAN && dlat > -SPAN && dlon < SPAN && dlon > -SPAN) begin
      d2 = dlat * dlat + dlon * dlon;
      lim = (d2 * DIST_COEF) >> 24;
      if (rate > lim) rate = lim;
      if (rate < -lim) rate = -lim;
    end
    if (reverse != 0) rate = -rate;
    if (rate > 64'sd2147483647) rate = 64'sd2147483647;
    if (rate < -64'sd2147483648) rate = -64'sd2147483648;
    c.speed = cruise[15:0];
    c.rate  = rate[31:0];
    c.err   = err[15:0];
    return c;
  endfunction

  // compare each result transfer with the oldest pending command
  always @(negedge clk_i) begin
    steer_cmd_t e;
    if (rst_ni && cmd_bus.valid && cmd_bus.ready) begin
      if (cmd_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result rate=%0d err=%0d",
                                  cmd_bus.angular_rate, cmd_bus.heading_error);
      end else begin
        e = cmd_q.pop_front();
        if (cmd_bus.linear_speed !== e.speed || cmd_bus.angular_rate !== e.rate ||
            cmd_bus.heading_error !== e.err) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: expected speed=%0d rate=%0d err=%0d, got %0d %0d %0d",
                     e.speed, e.rate, e.err, cmd_bus.linear_speed,
                     cmd_bus.angular_rate, cmd_bus.heading_error);
        end
      end
    end
  end

  function automatic tick_t mk_tick(logic fix, longint flat, longint flon, longint tlat,
                                    longint tlon, longint vn, longint ve, longint tick);
    tick_t t;
    t.fix = fix;
    t.flat = flat[30:0];
    t.flon = flon[31:0];
    t.tlat = tlat[30:0];
    t.tlon = tlon[31:0];
    t.vn = vn[17:0];
    t.ve = ve[17:0];
    t.tick = tick[29:0];
    t.typed = 0;
    t.t_speed = '0;
    t.t_rate = '0;
    t.t_err = '0;
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int pick, span;
    longint flat, flon;
    pick = $urandom_range(99);
    if (pick < 15) begin
      // noise: raw bits everywhere
      t = mk_tick(pick >= 6, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
      return t;
    end
    span = ($urandom_range(3) == 0) ? 1500000 : 100000;
    flat = longint'($urandom_range(1800000000)) - 900000000;
    flon = longint'($urandom_range(32'd3600000000)) - 1800000000;
    t = mk_tick(1'b1, flat, flon,
                flat + longint'($urandom_range(2 * span)) - span,
                flon + longint'($urandom_range(2 * span)) - span,
                longint'($urandom_range(4000)) - 2000,
                longint'($urandom_range(4000)) - 2000,
                ($urandom_range(3) == 0) ? $urandom_range(999999999)
                                          : $urandom_range(150000000));
    if ($urandom_range(15) == 0) t.vn = '0;
    if ($urandom_range(15) == 0) t.ve = '0;
    if ($urandom_range(15) == 0) begin
      t.tlat = t.flat; t.tlon = t.flon;
    end
    return t;
  endfunction

  // offer one tick; entered and left just after a rising edge
  task automatic send_tick(tick_t t);
    if ($urandom_range(99) < src_idle) begin
      tick_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    tick_bus.valid      <= 1'b1;
    tick_bus.fix_valid  <= t.fix;
    tick_bus.fix_lat    <= t.flat;
    tick_bus.fix_lon    <= t.flon;
    tick_bus.target_lat <= t.tlat;
    tick_bus.target_lon <= t.tlon;
    tick_bus.vel_north  <= t.vn;
    tick_bus.vel_east   <= t.ve;
    tick_bus.tick_ns    <= t.tick;
    do @(negedge clk_i); while (!tick_bus.ready);
    // the transfer lands on the coming edge
    if (t.fix) begin
      steer_cmd_t c;
      c = steer_predict(t);
      if (t.typed) begin
        c.speed = t.t_speed; c.rate = t.t_rate; c.err = t.t_err;
      end
      cmd_q.push_back(c);
    end
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, longint val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[15:0];
    case (idx)
      REG_CRUISE:  cruise  = val & 16'hFFFF;
      REG_HGAIN:   hgain   = val & 16'hFFFF;
      REG_IGAIN:   igain   = val & 16'hFFFF;
      REG_REVERSE: reverse = val & 1;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // drain every pending command, then let a dropped tick finish too
  task automatic settle();
    tick_bus.valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  tick_t rows[$];

  initial begin
    tick_t t;
    cycles = 0;
    fails = 0;
    src_idle = 35;
    snk_idle = 78;
    cruise = 1500; hgain = 128; igain = 0; reverse = 0; integ = 0;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_CRUISE;
    cfg_data <= '0;
    tick_bus.valid <= 1'b0;
    tick_bus.fix_valid <= 1'b0;
    tick_bus.fix_lat <= '0;
    tick_bus.fix_lon <= '0;
    tick_bus.target_lat <= '0;
    tick_bus.target_lon <= '0;
    tick_bus.vel_north <= '0;
    tick_bus.vel_east <= '0;
    tick_bus.tick_ns <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows; standing still right after reset gives a plain cruise command
    t = mk_tick(1, 100, 200, 5000, 6000, 0, 0, 100000000);
    t.typed = 1; t.t_speed = 16'd1500; t.t_rate = 0; t.t_err = 0;
    rows.push_back(t);
    // heading straight away from the waypoint, cross term exactly zero
    t = mk_tick(1, 1000, 0, 0, 0, 1000, 0, 0);
    t.typed = 1; t.t_speed = 16'd1500; t.t_rate = 13288; t.t_err = 16'sd25736;
    rows.push_back(t);
    // sitting on the waypoint: zero target vector
    t = mk_tick(1, 12345, -777, 12345, -777, 900, -900, 1000);
    t.typed = 1; t.t_speed = 16'd1500; t.t_rate = 0; t.t_err = 0;
    rows.push_back(t);
    rows.push_back(mk_tick(0, 5, 5, 9, 9, 700, 700, 5));
    rows.push_back(mk_tick(0, -1, -1, -1, -1, -1, -1, 32'h3FFFFFFF));
    rows.push_back(mk_tick(1, -900000000, -1800000000, 900000000, 1800000000,
                           131071, -131072, 999999999));
    rows.push_back(mk_tick(1, 900000000, 1800000000, -900000000, -1800000000,
                           -131072, 131071, 0));
    rows.push_back(mk_tick(1, 0, 0, 400000, 300000, 131071, 131071, 999999999));
    rows.push_back(mk_tick(1, 0, 0, -400000, -300000, -131072, -131072,
                           32'h3FFFFFFF));
    rows.push_back(mk_tick(1, 32'h3FFFFFFF, 0, 32'h3FFFFFFF, 1000, 700, 0, 50000000));
    rows.push_back(mk_tick(1, -32'sh40000000, 32'h7FFFFFFF, -32'sh40000000,
                           -32'sh80000000, 0, 800, 50000000));
    rows.push_back(mk_tick(1, 450000000, 100, 450000100, 100, 0, 550, 100000000));
    rows.push_back(mk_tick(1, 0, 0, 0, 1, 600, 0, 100000000));
    rows.push_back(mk_tick(1, 0, 0, 100, 0, 0, -1, 100000000));
    rows.push_back(mk_tick(1, 0, 0, 524287, 0, 1000, 1000, 200000000));
    rows.push_back(mk_tick(1, 0, 0, 524288, 0, -1000, 1000, 200000000));
    rows.push_back(mk_tick(1, 0, 0, -524288, -524288, 500, 1, 200000000));
    foreach (rows[i]) send_tick(rows[i]);
    settle();

    // random phases, a register setting each; extremes first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_CRUISE, 0); write_reg(REG_HGAIN, 65535);
          write_reg(REG_IGAIN, 65535); write_reg(REG_REVERSE, 1);
        end
        1: begin
          write_reg(REG_CRUISE, 65535); write_reg(REG_HGAIN, 0);
          write_reg(REG_IGAIN, 0); write_reg(REG_REVERSE, 0);
        end
        default: begin
          write_reg(REG_CRUISE, $urandom_range(65535));
          write_reg(REG_HGAIN, $urandom_range(2047));
          write_reg(REG_IGAIN, $urandom_range(65535));
          write_reg(REG_REVERSE, $urandom_range(1));
        end
      endcase
      // idle pattern: receiver heavy, then sender heavy, then none
      src_idle = (ph < 2) ? 35 : (ph < 4) ? 78 : 0;
      snk_idle = (ph < 2) ? 78 : (ph < 4) ? 35 : 0;
      repeat (75) send_tick(random_tick());
      settle();
    end

    if (fails == 0) $display("PASS gps_heading_steering_controller_top");
    else $display("FAIL gps_heading_steering_controller_top");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gpshsc_pkg.sv
rtl/core/gpshsc_if.sv
rtl/core/gpshsc_mul.sv
rtl/core/gps_heading_steering_controller_top.sv
tb/gps_heading_steering_controller_top_tb.sv
